@@ rtl/latest_value_topic_table_defines.svh @@
// assertion macros for the latest value topic table
// used by the back end module; no other dependencies
`ifndef LATEST_VALUE_TOPIC_TABLE_DEFINES_SVH
`define LATEST_VALUE_TOPIC_TABLE_DEFINES_SVH

`ifndef SYNTH
// property must hold at every edge outside reset
`define LTT_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("ltt assertion failed");
// condition must never be true outside reset
`define LTT_NEVER(lbl, clk, rst_n, cond) \
	`LTT_ASSERT(lbl, clk, rst_n, !(cond))
`else
`define LTT_ASSERT(lbl, clk, rst_n, prop)
`define LTT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

@@ rtl/ltt_pkg.sv @@
// shared types and codes for the latest value topic table
// no dependencies
package ltt_pkg;

	localparam int KEY_W = 64;
	localparam int SEQ_W = 32;
	localparam int PAY_W = 64;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_STALE     = 2'd1,
		ST_FULL      = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	typedef enum logic {
		OP_PUT  = 1'b0,
		OP_FIND = 1'b1
	} op_t;

	// classified request as it sits in the queue
	typedef struct packed {
		op_t              op;
		logic [KEY_W-1:0] key;
		logic [SEQ_W-1:0] seq;
		logic [PAY_W-1:0] pay;
	} req_t;

	// one stored table entry
	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [SEQ_W-1:0] seq;
		logic [PAY_W-1:0] pay;
	} entry_t;

	// one result beat
	typedef struct packed {
		status_t          status;
		logic             hit;
		logic [SEQ_W-1:0] seq;
		logic [PAY_W-1:0] pay;
	} resp_t;

endpackage

@@ rtl/ltt_ram.sv @@
// generic single write, single read ram with registered read data
// no dependencies
module ltt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/ltt_front.sv @@
// front end: takes input beats, decodes the command, hands requests on
// depends on ltt_pkg
module ltt_front
	import ltt_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             cmd,
	input  logic [KEY_W-1:0] topic_key,
	input  logic [SEQ_W-1:0] sequence_req,
	input  logic [PAY_W-1:0] payload,
	output logic             push_valid,
	input  logic             push_ready,
	output req_t             push_data
);

	logic stg_valid_q;
	req_t stg_q;
	logic accept;

	assign in_ready = !stg_valid_q || push_ready;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stg_valid_q <= 1'b0;
		end else if (accept) begin
			stg_valid_q <= 1'b1;
		end else if (push_ready) begin
			stg_valid_q <= 1'b0;
		end
	end

	// put carries sequence and payload, find only the key
	always_ff @(posedge clk) begin
		if (accept) begin
			stg_q.op  <= op_t'(cmd);
			stg_q.key <= topic_key;
			stg_q.seq <= (op_t'(cmd) == OP_PUT) ? sequence_req : '0;
			stg_q.pay <= (op_t'(cmd) == OP_PUT) ? payload : '0;
		end
	end

	assign push_valid = stg_valid_q;
	assign push_data  = stg_q;

endmodule

@@ rtl/ltt_queue.sv @@
// two entry request queue between front and back end
// depends on ltt_pkg
module ltt_queue
	import ltt_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  req_t push_data,
	output logic pop_valid,
	input  logic pop_ready,
	output req_t pop_data
);

	req_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	logic       push;
	logic       pop;

	assign push_ready = (fill_q != 2'd2);
	assign pop_valid  = (fill_q != 2'd0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

@@ rtl/ltt_back.sv @@
// back end: scans the entry ram for the key, updates it, forms the result
// depends on ltt_pkg, ltt_ram and the assertion macro header
`include "latest_value_topic_table_defines.svh"

module ltt_back
	import ltt_pkg::*;
#(
	parameter int ENTRIES = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req_data,
	output logic out_valid,
	input  logic out_ready,
	output resp_t out_data
);

	localparam int CW = $clog2(ENTRIES + 1);
	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_SCAN   = 3'b010,
		S_DECIDE = 3'b100
	} state_t;

	state_t           state_q;
	req_t             req_q;
	logic [CW-1:0]    count_q;
	logic [CW-1:0]    scan_q;
	logic [CW-1:0]    scan_next;
	logic             match_q;
	logic [IW-1:0]    match_idx_q;
	logic [SEQ_W-1:0] match_seq_q;
	logic [PAY_W-1:0] match_pay_q;
	logic             out_valid_q;
	resp_t            resp_q;

	logic             pop;
	logic             key_eq;
	logic             go;
	logic             ram_we;
	logic [IW-1:0]    ram_waddr;
	logic [IW-1:0]    ram_raddr;
	entry_t           ram_wdata;
	entry_t           ram_rdata;
	resp_t            resp;
	logic             do_write;
	logic             do_append;

	ltt_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(ENTRIES)
	) u_entry_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign req_ready = (state_q == S_IDLE);
	assign pop       = req_valid && req_ready;
	assign scan_next = scan_q + 1'b1;
	assign key_eq    = (ram_rdata.key == req_q.key);
	assign go        = (state_q == S_DECIDE) && (!out_valid_q || out_ready);

	// read pointer runs one entry ahead of the compare
	assign ram_raddr = (state_q == S_SCAN) ? scan_next[IW-1:0] : '0;

	always_comb begin
		resp      = '0;
		do_write  = 1'b0;
		do_append = 1'b0;
		if (req_q.op == OP_FIND) begin
			if (match_q) begin
				resp.status = ST_OK;
				resp.hit    = 1'b1;
				resp.seq    = match_seq_q;
				resp.pay    = match_pay_q;
			end else begin
				resp.status = ST_NOT_FOUND;
			end
		end else if (match_q) begin
			resp.hit = 1'b1;
			if (req_q.seq > match_seq_q) begin
				resp.status = ST_OK;
				do_write    = 1'b1;
			end else begin
				resp.status = ST_STALE;
			end
		end else if (count_q == CW'(ENTRIES)) begin
			resp.status = ST_FULL;
		end else begin
			resp.status = ST_OK;
			do_write    = 1'b1;
			do_append   = 1'b1;
		end
	end

	assign ram_we        = go && do_write;
	assign ram_waddr     = do_append ? count_q[IW-1:0] : match_idx_q;
	assign ram_wdata.key = req_q.key;
	assign ram_wdata.seq = req_q.seq;
	assign ram_wdata.pay = req_q.pay;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			scan_q      <= '0;
			match_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (pop) begin
						scan_q  <= '0;
						match_q <= 1'b0;
						state_q <= (count_q == '0) ? S_DECIDE : S_SCAN;
					end
				end
				S_SCAN: begin
					if (key_eq) begin
						match_q <= 1'b1;
						state_q <= S_DECIDE;
					end else if (scan_next == count_q) begin
						state_q <= S_DECIDE;
					end else begin
						scan_q <= scan_next;
					end
				end
				S_DECIDE: begin
					if (go) begin
						state_q <= S_IDLE;
						if (do_append) begin
							count_q <= count_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			if (go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			req_q <= req_data;
		end
		if ((state_q == S_SCAN) && key_eq) begin
			match_idx_q <= scan_q[IW-1:0];
			match_seq_q <= ram_rdata.seq;
			match_pay_q <= ram_rdata.pay;
		end
		if (go) begin
			resp_q <= resp;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = resp_q;

	`LTT_ASSERT(a_count_bound, clk, arst_n, count_q <= CW'(ENTRIES))
	`LTT_NEVER(a_write_in_decide, clk, arst_n, ram_we && (state_q != S_DECIDE))
	`LTT_ASSERT(a_count_step, clk, arst_n, (count_q != $past(count_q)) |-> (count_q == $past(count_q) + 1'b1))
	`LTT_ASSERT(a_scan_range, clk, arst_n, (state_q == S_SCAN) |-> (scan_q < count_q))

endmodule

@@ rtl/latest_value_topic_table.sv @@
// flow: an item is decoded and registered in the front end, queued, then
// the back end starts, compares filled entries in turn up to a key match,
// then decides once the result register is free; a new item is taken only
// when idle, so the scan through the single ram read port sets the pace
// reset: asynchronous active low, empties the table and all queues; the
// entry ram is not cleared and only entries below the fill count are compared
module latest_value_topic_table
	import ltt_pkg::*;
#(
	parameter int ENTRIES = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	// request channel
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             cmd,
	input  logic [KEY_W-1:0] topic_key,
	input  logic [SEQ_W-1:0] sequence_req,
	input  logic [PAY_W-1:0] payload,
	// result channel
	output logic             out_valid,
	input  logic             out_ready,
	output logic [1:0]       status,
	output logic             hit,
	output logic [SEQ_W-1:0] stored_sequence,
	output logic [PAY_W-1:0] stored_payload
);

	// front to queue
	logic  fq_valid;
	logic  fq_ready;
	req_t  fq_data;
	// queue to back end
	logic  qb_valid;
	logic  qb_ready;
	req_t  qb_data;
	// result beat
	resp_t resp;

	// front end: input stage and command decode
	ltt_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.cmd         (cmd),
		.topic_key   (topic_key),
		.sequence_req(sequence_req),
		.payload     (payload),
		.push_valid  (fq_valid),
		.push_ready  (fq_ready),
		.push_data   (fq_data)
	);

	// decouples input acceptance from the scan
	ltt_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(fq_valid),
		.push_ready(fq_ready),
		.push_data (fq_data),
		.pop_valid (qb_valid),
		.pop_ready (qb_ready),
		.pop_data  (qb_data)
	);

	// back end: key scan, sequence check, write back, output register
	ltt_back #(
		.ENTRIES(ENTRIES)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(qb_valid),
		.req_ready(qb_ready),
		.req_data (qb_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (resp)
	);

	// unpack the result beat onto its ports
	assign status          = resp.status;
	assign hit             = resp.hit;
	assign stored_sequence = resp.seq;
	assign stored_payload  = resp.pay;

endmodule

@@ bench/ltt_checker.sv @@
// result checker for the latest value topic table
// depends on ltt_pkg for field widths, op and status codes
module ltt_checker
	import ltt_pkg::*;
#(
	parameter int ENTRIES = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_ready,
	input  logic             cmd,
	input  logic [KEY_W-1:0] topic_key,
	input  logic [SEQ_W-1:0] sequence_req,
	input  logic [PAY_W-1:0] payload,
	input  logic             out_valid,
	input  logic             out_ready,
	input  logic [1:0]       status,
	input  logic             hit,
	input  logic [SEQ_W-1:0] stored_sequence,
	input  logic [PAY_W-1:0] stored_payload,
	output int               mismatch_count,
	output int               answers_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	// shadow of the topic table, filled in insertion order
	entry_t      topics [ENTRIES];
	int unsigned topic_count;
	resp_t       answers_due [$];

	function automatic int find_topic(logic [KEY_W-1:0] key);
		for (int i = 0; i < topic_count; i++) begin
			if (topics[i].key == key)
				return i;
		end
		return -1;
	endfunction

	// works out the answer to one request and updates the shadow table
	function automatic resp_t predict_answer(op_t op, logic [KEY_W-1:0] key,
			logic [SEQ_W-1:0] seq, logic [PAY_W-1:0] pay);
		resp_t ans;
		int    idx;
		ans = '0;
		idx = find_topic(key);
		if (op == OP_FIND) begin
			if (idx >= 0) begin
				ans.status = ST_OK;
				ans.hit    = 1'b1;
				ans.seq    = topics[idx].seq;
				ans.pay    = topics[idx].pay;
			end else begin
				ans.status = ST_NOT_FOUND;
			end
		end else if (idx >= 0) begin
			ans.hit = 1'b1;
			// equal sequence is stale too
			if (seq <= topics[idx].seq) begin
				ans.status = ST_STALE;
			end else begin
				topics[idx].seq = seq;
				topics[idx].pay = pay;
				ans.status      = ST_OK;
			end
		end else if (topic_count >= ENTRIES) begin
			ans.status = ST_FULL;
		end else begin
			topics[topic_count] = '{key: key, seq: seq, pay: pay};
			topic_count++;
			ans.status = ST_OK;
		end
		return ans;
	endfunction

	task automatic check_answer(resp_t want);
		if (status !== want.status) begin
			$error("status: expected %0d, got %0d", want.status, status);
			mismatch_count++;
		end
		if (hit !== want.hit) begin
			$error("hit: expected %0d, got %0d", want.hit, hit);
			mismatch_count++;
		end
		if (stored_sequence !== want.seq) begin
			$error("stored_sequence: expected %h, got %h", want.seq, stored_sequence);
			mismatch_count++;
		end
		if (stored_payload !== want.pay) begin
			$error("stored_payload: expected %h, got %h", want.pay, stored_payload);
			mismatch_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			topic_count = 0;
			answers_due.delete();
		end else begin
			if (in_valid && in_ready)
				answers_due.push_back(predict_answer(op_t'(cmd), topic_key,
					sequence_req, payload));
			if (out_valid && out_ready) begin
				if (answers_due.size() == 0) begin
					$error("result beat with no request outstanding");
					mismatch_count++;
				end else begin
					check_answer(answers_due.pop_front());
				end
			end
		end
		answers_pending = answers_due.size();
	end

endmodule

@@ bench/tb_latest_value_topic_table.sv @@
// testbench top for the latest value topic table: drives requests and
// result back-pressure, gives the verdict; depends on ltt_pkg, ltt_checker
// and the rtl top module
module tb_latest_value_topic_table
	import ltt_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DIRECTED_ITEMS = 26;
	localparam int TOTAL_ITEMS    = 1950;
	// last stretch of the run goes without idling on either side
	localparam int CALM_AT        = TOTAL_ITEMS - 300;
	// long result hold-off, so the request queue fills and in_ready drops
	localparam int HOLD_AT        = 700;
	localparam int HOLD_CYCLES    = 400;
	// sender waits here until every answer is back
	localparam int DRAIN_AT       = 1300;
	localparam int TAIL_CYCLES    = 40;
	// hang limit for the whole run in ns, well above the expected run time
	localparam longint LIMIT_NS   = 64'd10_000_000;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	logic             cmd = OP_PUT;
	logic [KEY_W-1:0] topic_key = '0;
	logic [SEQ_W-1:0] sequence_req = '0;
	logic [PAY_W-1:0] payload = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	logic [1:0]       status;
	logic             hit;
	logic [SEQ_W-1:0] stored_sequence;
	logic [PAY_W-1:0] stored_payload;

	int mismatch_count;
	int answers_pending;
	int items_sent = 0;
	bit calm = 1'b0;

	// 16 keys that the random part keeps hitting, extremes first
	logic [KEY_W-1:0] topic_pool [16];

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	latest_value_topic_table #(
		.ENTRIES(16)
	) DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.cmd            (cmd),
		.topic_key      (topic_key),
		.sequence_req   (sequence_req),
		.payload        (payload),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.hit            (hit),
		.stored_sequence(stored_sequence),
		.stored_payload (stored_payload)
	);

	ltt_checker #(
		.ENTRIES(16)
	) u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.cmd            (cmd),
		.topic_key      (topic_key),
		.sequence_req   (sequence_req),
		.payload        (payload),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.hit            (hit),
		.stored_sequence(stored_sequence),
		.stored_payload (stored_payload),
		.mismatch_count (mismatch_count),
		.answers_pending(answers_pending)
	);

	function automatic logic [63:0] rand_word64();
		return {$urandom, $urandom};
	endfunction

	// offers one request beat and returns at the edge that takes it,
	// sometimes followed by an idle burst
	task automatic send_request(op_t op, logic [KEY_W-1:0] key,
			logic [SEQ_W-1:0] seq, logic [PAY_W-1:0] pay);
		cmd          <= op;
		topic_key    <= key;
		sequence_req <= seq;
		payload      <= pay;
		in_valid     <= 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		items_sent++;
		if (items_sent >= CALM_AT)
			calm = 1'b1;
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
	endtask

	// request side
	initial begin
		op_t              op;
		logic [KEY_W-1:0] key;
		logic [SEQ_W-1:0] seq;
		logic [SEQ_W-1:0] last_seq;
		longint unsigned  seq_base;
		int               pick;

		topic_pool[0] = '0;
		topic_pool[1] = '1;
		for (int i = 2; i < 16; i++)
			topic_pool[i] = rand_word64();

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part
		// lookup on an empty table
		send_request(OP_FIND, topic_pool[0], $urandom, rand_word64());
		// appends with all-zero and all-one fields
		send_request(OP_PUT, topic_pool[0], '0, '0);
		send_request(OP_PUT, topic_pool[1], '1, '1);
		send_request(OP_FIND, topic_pool[0], $urandom, rand_word64());
		send_request(OP_FIND, topic_pool[1], $urandom, rand_word64());
		// stale: equal sequence, then lower sequence
		send_request(OP_PUT, topic_pool[0], '0, rand_word64());
		send_request(OP_PUT, topic_pool[1], 32'd5, rand_word64());
		// newer sequence replaces the entry in place
		send_request(OP_PUT, topic_pool[0], 32'd1, 64'hA5A5_A5A5_A5A5_A5A5);
		send_request(OP_FIND, topic_pool[0], $urandom, rand_word64());
		// fill the rest of the table
		for (int i = 2; i < 16; i++)
			send_request(OP_PUT, topic_pool[i], $urandom_range(0, 1000), rand_word64());
		// unknown key on a full table, then a lookup miss and a hit
		send_request(OP_PUT, rand_word64(), $urandom, rand_word64());
		send_request(OP_FIND, rand_word64(), $urandom, rand_word64());
		send_request(OP_FIND, topic_pool[15], $urandom, rand_word64());

		// random part: mostly known keys with a rising sequence so that
		// updates keep landing, mixed with stale repeats and unknown keys
		seq_base = 64'h8000_0000;
		last_seq = '0;
		for (int n = DIRECTED_ITEMS; n < TOTAL_ITEMS; n++) begin
			if (n == DRAIN_AT) begin
				in_valid <= 1'b0;
				@(posedge clk);
				wait (answers_pending == 0);
				@(posedge clk);
			end
			op  = ($urandom_range(0, 9) < 3) ? OP_FIND : OP_PUT;
			key = ($urandom_range(0, 99) < 85) ? topic_pool[$urandom_range(0, 15)]
				: rand_word64();
			pick = $urandom_range(0, 99);
			if (pick < 65) begin
				seq_base += $urandom_range(1, 1 << 20);
				seq = seq_base[SEQ_W-1:0];
			end else if (pick < 90) begin
				seq = $urandom_range(0, seq_base[SEQ_W-1:0]);
			end else begin
				seq = last_seq;
			end
			last_seq = seq;
			send_request(op, key, seq, rand_word64());
		end
		in_valid <= 1'b0;
		// let the checker log the last accepted beat first
		@(posedge clk);

		// drain, then let the pipeline settle before the verdict
		wait (answers_pending == 0);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && answers_pending == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// result side: ready bursts, idle bursts, and one long hold-off
	initial begin
		bit held_off;
		held_off = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (!held_off && items_sent >= HOLD_AT) begin
				held_off = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end
		end
	end

	// hang guard
	initial begin
		#(LIMIT_NS);
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
